[sv/lzss_td_pkg.sv]
package lzss_td_pkg;

  localparam int HIST_AW    = 14;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int SYM_W      = 9;
  localparam int LEN_W      = 8;
  localparam int MAX_LEN    = 1 << LEN_W;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int CFG_W      = 4;
  localparam int WORD_W     = 32;
  localparam int BCNT_W     = 3;
  localparam int LANES      = WORD_W / 8;

  localparam logic [SYM_W-1:0] END_MARK = SYM_W'(256);
  localparam logic [CFG_W-1:0] HB_RESET = CFG_W'(HIST_AW);
  localparam logic [CFG_W-1:0] LB_RESET = CFG_W'(7);
  localparam logic [CFG_W-1:0] HB_MAX   = CFG_W'(HIST_AW);
  localparam logic [CFG_W-1:0] LB_MAX   = CFG_W'(LEN_W);

  typedef enum logic [0:0] {
    CFG_HISTORY_BITS = 1'b0,
    CFG_LENGTH_BITS  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_FLUSH
  } eng_state_t;

  typedef struct packed {
    logic               is_match;
    logic [HIST_AW-1:0] distance_code;
    logic [LEN_W-1:0]   length_code;
    logic [SYM_W-1:0]   literal_symbol;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic [BCNT_W-1:0] byte_count;
    logic              token_done;
    logic              end_of_stream;
  } out_item_t;

  typedef struct packed {
    logic [HIST_AW-1:0] dist_mask;
    logic [LEN_W-1:0]   len_mask;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [SYM_W-1:0]   wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } ram_req_t;

endpackage

[sv/lzss_td_ram.sv]
module lzss_td_ram #(
  parameter int AW = 14,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lzss_td_cfg.sv]
module lzss_td_cfg import lzss_td_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  logic [CFG_W-1:0] hb_r, hb_nxt;
  logic [CFG_W-1:0] lb_r, lb_nxt;
  logic [CFG_W-1:0] hb_c, lb_c;

  always_comb begin
    hb_nxt = hb_r;
    lb_nxt = lb_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_HISTORY_BITS: hb_nxt = cfg_wdata;
        CFG_LENGTH_BITS:  lb_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r <= HB_RESET;
      lb_r <= LB_RESET;
    end else begin
      hb_r <= hb_nxt;
      lb_r <= lb_nxt;
    end
  end

  // saturate out-of-range widths to the usable span
  always_comb begin
    hb_c = hb_r;
    if (hb_r == '0) hb_c = CFG_W'(1);
    else if (hb_r > HB_MAX) hb_c = HB_MAX;
    lb_c = lb_r;
    if (lb_r == '0) lb_c = CFG_W'(1);
    else if (lb_r > LB_MAX) lb_c = LB_MAX;
    cfg.dist_mask = {HIST_AW{1'b1}} >> (HB_MAX - hb_c);
    cfg.len_mask  = {LEN_W{1'b1}} >> (LB_MAX - lb_c);
  end

endmodule

[sv/lzss_td_engine.sv]
module lzss_td_engine import lzss_td_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  output ram_req_t         ram_req,
  input  logic [SYM_W-1:0] ram_rdata
);

  eng_state_t         state_r, state_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [HIST_AW-1:0] src_r, src_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               s2_valid_r, s2_valid_nxt;
  logic               emit_r, emit_nxt;
  logic [WORD_W-1:0]  acc_r, acc_nxt;
  logic [BCNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               hit_r, fwd_r;
  logic [SYM_W-1:0]   fwd_data_r;

  logic             out_free, accept, issue, s2_adv, emit_byte;
  logic [SYM_W-1:0] sym;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    s2_valid_nxt  = s2_valid_r;
    emit_nxt      = emit_r;
    acc_nxt       = acc_r;
    acc_cnt_nxt   = acc_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    out_free = !out_valid_r || out_ready;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // a slot never written since reset reads as the end marker
    sym       = fwd_r ? fwd_data_r : (hit_r ? ram_rdata : END_MARK);
    emit_byte = s2_valid_r && emit_r && (sym != END_MARK);
    s2_adv    = s2_valid_r &&
                !(emit_byte && (acc_cnt_r == BCNT_W'(LANES)) && !out_free);
    issue     = (state_r == ST_COPY) && (left_r != '0) && (!s2_valid_r || s2_adv);

    in_ready = (state_r == ST_IDLE) && out_free;
    accept   = in_valid && in_ready;

    ram_req.we    = 1'b0;
    ram_req.waddr = wp_r;
    ram_req.wdata = sym;
    ram_req.re    = issue;
    ram_req.raddr = src_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_data.is_match) begin
            out_valid_nxt         = 1'b1;
            out_nxt.token_done    = 1'b1;
            if (in_data.literal_symbol == END_MARK) begin
              out_nxt.data_word     = '0;
              out_nxt.byte_count    = '0;
              out_nxt.end_of_stream = 1'b1;
            end else begin
              ram_req.we            = 1'b1;
              ram_req.wdata         = in_data.literal_symbol;
              wp_nxt                = wp_r + HIST_AW'(1);
              if (wp_r == '1) wrapped_nxt = 1'b1;
              out_nxt.data_word     = WORD_W'(in_data.literal_symbol[7:0]);
              out_nxt.byte_count    = BCNT_W'(1);
              out_nxt.end_of_stream = 1'b0;
            end
          end else begin
            src_nxt     = wp_r - (in_data.distance_code & cfg.dist_mask) - HIST_AW'(1);
            left_nxt    = CNT_W'(in_data.length_code & cfg.len_mask) + CNT_W'(1);
            emit_nxt    = 1'b1;
            acc_nxt     = '0;
            acc_cnt_nxt = '0;
            state_nxt   = ST_COPY;
          end
        end
      end

      ST_COPY: begin
        if (s2_adv) begin
          ram_req.we = 1'b1;
          wp_nxt     = wp_r + HIST_AW'(1);
          if (wp_r == '1) wrapped_nxt = 1'b1;
          if (emit_r && (sym == END_MARK)) emit_nxt = 1'b0;
          if (emit_byte) begin
            if (acc_cnt_r == BCNT_W'(LANES)) begin
              // a further byte proves the full word is not the last one
              out_valid_nxt         = 1'b1;
              out_nxt.data_word     = acc_r;
              out_nxt.byte_count    = acc_cnt_r;
              out_nxt.token_done    = 1'b0;
              out_nxt.end_of_stream = 1'b0;
              acc_nxt               = WORD_W'(sym[7:0]);
              acc_cnt_nxt           = BCNT_W'(1);
            end else begin
              acc_nxt[{acc_cnt_r[1:0], 3'b000} +: 8] = sym[7:0];
              acc_cnt_nxt = acc_cnt_r + BCNT_W'(1);
            end
          end
        end
        if (issue) begin
          src_nxt      = src_r + HIST_AW'(1);
          left_nxt     = left_r - CNT_W'(1);
          s2_valid_nxt = 1'b1;
        end else if (s2_adv) begin
          s2_valid_nxt = 1'b0;
        end
        if ((left_r == '0) && (!s2_valid_r || s2_adv)) state_nxt = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.data_word     = acc_r;
          out_nxt.byte_count    = acc_cnt_r;
          out_nxt.token_done    = 1'b1;
          out_nxt.end_of_stream = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    left_r    <= left_nxt;
    emit_r    <= emit_nxt;
    acc_r     <= acc_nxt;
    acc_cnt_r <= acc_cnt_nxt;
    out_r     <= out_nxt;
    // capture fill status and bypass the write that lands on the read slot
    if (issue) begin
      hit_r      <= wrapped_r || (src_r < wp_r);
      fwd_r      <= ram_req.we && (wp_r == src_r);
      fwd_data_r <= sym;
    end
  end

endmodule

[sv/lzss_token_decoder_top.sv]
// LZSS token decoder.
// Input channel (in_valid/in_ready/in_data): one parsed token per item, either a
// literal symbol or a distance/length match. Output channel (out_valid/out_ready/
// out_data): decoded bytes packed up to four per item, first byte in bits 7:0,
// with token_done on the last item of each token and end_of_stream for the
// end literal. cfg_we/cfg_idx/cfg_wdata set history_bits and length_bits; write
// them only while no token is in flight.
// A literal's item appears in the cycle after the literal is taken.
// A match passes through the accepting cycle, one history read per copied
// symbol through the single read port, a write-back of the last symbol, then
// the hand-over of the final word. The next token can be taken in the cycle
// that final word appears. Tokens are processed one at a time.
// Reset empties the history: slots not yet written read as the end marker, so
// the block is ready straight after reset with no clearing pass.
// A stalled receiver holds the output register; a match then pauses once a
// further word is ready and resumes when the receiver takes the pending item.
module lzss_token_decoder_top import lzss_td_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t             cfg;
  ram_req_t         ram_req;
  logic [SYM_W-1:0] ram_rdata;

  lzss_td_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lzss_td_ram #(
    .AW (HIST_AW),
    .DW (SYM_W)
  ) u_hist (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  lzss_td_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

[sv/lzss_td_checker.sv]
module lzss_td_props import lzss_td_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.byte_count <= BCNT_W'(LANES))
    else $error("byte count above four");

  // only the last item of a token may be short
  a_full_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.token_done |-> out_data.byte_count == BCNT_W'(LANES))
    else $error("partial word before end of token");

  a_eos_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_stream |->
      out_data.token_done && (out_data.byte_count == '0) && (out_data.data_word == '0))
    else $error("malformed end-of-stream item");

  // a new token is only taken while the output register can move
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while output item is stalled");

endmodule

bind lzss_token_decoder_top lzss_td_props u_chk (.*);

[tb/lzss_td_checker.sv]
module lzss_td_checker import lzss_td_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               tokens_seen,
  output int               matches_seen,
  output int               results_seen,
  output int               bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [SYM_W-1:0]   ring [HIST_DEPTH];
  logic [HIST_AW-1:0] ring_wp;
  logic [CFG_W-1:0]   dist_bits;
  logic [CFG_W-1:0]   len_bits;
  out_item_t          decoded_words [$];

  // Work out the words one token yields and advance the history with it.
  function automatic void decode_token(input in_item_t tok);
    logic [7:0]       copied [$];
    logic [SYM_W-1:0] sym;
    int unsigned      hb, lb, back, len, src, nwords, p;
    bit               emitting;
    out_item_t        word;
    if (!tok.is_match) begin
      word = '0;
      word.token_done = 1'b1;
      if (tok.literal_symbol == END_MARK) begin
        word.end_of_stream = 1'b1;
      end else begin
        ring[ring_wp] = tok.literal_symbol;
        ring_wp = ring_wp + 1'b1;
        word.data_word[7:0] = tok.literal_symbol[7:0];
        word.byte_count = BCNT_W'(1);
      end
      decoded_words.push_back(word);
    end else begin
      hb = (dist_bits == 0) ? 1 : (dist_bits > HB_MAX) ? HB_MAX : dist_bits;
      lb = (len_bits == 0) ? 1 : (len_bits > LB_MAX) ? LB_MAX : len_bits;
      back = (int'(tok.distance_code) & ((1 << hb) - 1)) + 1;
      len = (int'(tok.length_code) & ((1 << lb) - 1)) + 1;
      if (len > MAX_LEN) len = MAX_LEN;
      if (back > HIST_DEPTH) back = HIST_DEPTH;
      src = (int'(ring_wp) + HIST_DEPTH - back) % HIST_DEPTH;
      emitting = 1'b1;
      // Copy one symbol at a time so overlapping copies repeat fresh data.
      for (int i = 0; i < len; i++) begin
        sym = ring[src];
        ring[ring_wp] = sym;
        ring_wp = ring_wp + 1'b1;
        src = (src + 1) % HIST_DEPTH;
        if (emitting) begin
          if (sym == END_MARK) emitting = 1'b0;
          else copied.push_back(sym[7:0]);
        end
      end
      nwords = (copied.size() + 3) / 4;
      if (nwords == 0) nwords = 1;
      for (int k = 0; k < nwords; k++) begin
        word = '0;
        for (int j = 0; j < LANES; j++) begin
          p = k * LANES + j;
          if (p < copied.size()) begin
            word.data_word[8*j +: 8] = copied[p];
            word.byte_count = word.byte_count + 1'b1;
          end
        end
        word.token_done = (k == nwords - 1);
        decoded_words.push_back(word);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) ring[i] = END_MARK;
      ring_wp = '0;
      dist_bits = HB_RESET;
      len_bits = LB_RESET;
      decoded_words.delete();
      fail_count = 0;
      tokens_seen = 0;
      matches_seen = 0;
      results_seen = 0;
      bytes_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HISTORY_BITS: dist_bits = cfg_wdata;
          CFG_LENGTH_BITS:  len_bits = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        bytes_seen += out_data.byte_count;
        if (decoded_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result: word=%h count=%0d done=%b eos=%b",
                     $realtime, out_data.data_word, out_data.byte_count,
                     out_data.token_done, out_data.end_of_stream);
        end else begin
          want = decoded_words.pop_front();
          if (out_data.data_word !== want.data_word ||
              out_data.byte_count !== want.byte_count ||
              out_data.token_done !== want.token_done ||
              out_data.end_of_stream !== want.end_of_stream) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch: expected word=%h count=%0d done=%b eos=%b",
                       $realtime, want.data_word, want.byte_count, want.token_done,
                       want.end_of_stream);
              $display("[%0t]           actual   word=%h count=%0d done=%b eos=%b",
                       $realtime, out_data.data_word, out_data.byte_count,
                       out_data.token_done, out_data.end_of_stream);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        tokens_seen++;
        if (in_data.is_match) matches_seen++;
        decode_token(in_data);
      end
    end
    pending = decoded_words.size();
  end

endmodule

[tb/tb_lzss_token_decoder_top.sv]
module tb_lzss_token_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_td_pkg::*;

  localparam int     NUM_PHASES  = 8;
  localparam int     PHASE_ITEMS = 55;
  localparam int     LONG_HOLD   = 400;
  localparam int     SETTLE      = 8;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  cfg_idx_t         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  int     fail_count, pending, tokens_seen, matches_seen, results_seen, bytes_seen;
  bit     idle_on;
  int     hold_req = 0;
  int     hold_done = 0;
  longint cycle_count = 0;

  logic [CFG_W-1:0] phase_hb [NUM_PHASES] = '{4'd0, 4'd15, 4'd1, 4'd14, 4'd5, 4'd9, 4'd2, 4'd14};
  logic [CFG_W-1:0] phase_lb [NUM_PHASES] = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd4, 4'd3, 4'd6, 4'd7};

  lzss_token_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lzss_td_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .tokens_seen  (tokens_seen),
    .matches_seen (matches_seen),
    .results_seen (results_seen),
    .bytes_seen   (bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done++;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 18);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t literal_token(input logic [SYM_W-1:0] sym);
    in_item_t tok;
    tok = in_item_t'($urandom);
    tok.is_match = 1'b0;
    tok.literal_symbol = sym;
    return tok;
  endfunction

  function automatic in_item_t match_token(input logic [HIST_AW-1:0] dcode,
                                           input logic [LEN_W-1:0] lcode);
    in_item_t tok;
    tok = in_item_t'($urandom);
    tok.is_match = 1'b1;
    tok.distance_code = dcode;
    tok.length_code = lcode;
    return tok;
  endfunction

  // Mostly literals and matches that reach back into written data; junk in the
  // masked-off code bits, and a share of matches with fully random codes.
  function automatic in_item_t random_token(input int unsigned fill,
                                            input logic [CFG_W-1:0] hb_cfg,
                                            input logic [CFG_W-1:0] lb_cfg);
    in_item_t           tok;
    int unsigned        pick, hb, lb, reach, dlow, llow;
    logic [HIST_AW-1:0] dmask;
    logic [LEN_W-1:0]   lmask;
    tok = in_item_t'($urandom);
    hb = (hb_cfg == 0) ? 1 : (hb_cfg > HB_MAX) ? HB_MAX : hb_cfg;
    lb = (lb_cfg == 0) ? 1 : (lb_cfg > LB_MAX) ? LB_MAX : lb_cfg;
    dmask = HIST_AW'((1 << hb) - 1);
    lmask = LEN_W'((1 << lb) - 1);
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      tok.is_match = 1'b0;
      tok.literal_symbol = SYM_W'($urandom_range(0, 255));
    end else if (pick < 47) begin
      tok.is_match = 1'b0;
      tok.literal_symbol = END_MARK;
    end else if (pick < 50) begin
      tok.is_match = 1'b0;
      tok.literal_symbol = SYM_W'($urandom_range(257, 511));
    end else if (pick < 90) begin
      tok.is_match = 1'b1;
      reach = fill;
      if (reach > 64) reach = 64;
      if (reach > (1 << hb)) reach = 1 << hb;
      if (reach == 0) reach = 1;
      dlow = $urandom_range(0, reach - 1);
      llow = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 11);
      tok.distance_code = (tok.distance_code & ~dmask) | (HIST_AW'(dlow) & dmask);
      tok.length_code = (tok.length_code & ~lmask) | (LEN_W'(llow) & lmask);
    end else begin
      tok.is_match = 1'b1;
    end
    return tok;
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_token(input in_item_t tok);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= tok;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] hb, input logic [CFG_W-1:0] lb);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_HISTORY_BITS;
    cfg_wdata <= hb;
    @(negedge clk);
    cfg_idx <= CFG_LENGTH_BITS;
    cfg_wdata <= lb;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t    opening [$];
    in_item_t    tok;
    int unsigned fill;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_HISTORY_BITS;
    cfg_wdata = '0;
    idle_on = 1'b0;
    fill = 0;
    phase_hb[5] = CFG_W'($urandom_range(0, 15));
    phase_lb[5] = CFG_W'($urandom_range(0, 15));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at reset settings: empty history, literal extremes,
    // end of stream, overlapping copy, oldest entry, masked length.
    opening.push_back(match_token(14'd0, 8'd3));
    opening.push_back(literal_token(9'h000));
    opening.push_back(literal_token(9'h0FF));
    opening.push_back(literal_token(END_MARK));
    opening.push_back(literal_token(9'h1FF));
    opening.push_back(literal_token(9'h1A5));
    opening.push_back(literal_token(9'h041));
    opening.push_back(match_token(14'd0, 8'd9));
    opening.push_back(match_token(14'd4, 8'd20));
    opening.push_back(match_token(14'h3FFF, 8'd4));
    opening.push_back(match_token(14'd20, 8'd30));
    opening.push_back(match_token(14'd3, 8'hFF));
    opening.push_back(literal_token(END_MARK));
    opening.push_back(literal_token(9'h080));
    foreach (opening[i]) send_token(opening[i]);
    fill = 6;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      set_config(phase_hb[p], phase_lb[p]);
      idle_on = (p != NUM_PHASES - 1);
      if (p == 0) begin
        // Longest match over a two-symbol window: most result words per token.
        send_token(literal_token(9'h05A));
        send_token(literal_token(9'h0C3));
        send_token(match_token(14'h3FFF, 8'hFF));
        fill += 2;
      end
      if (p == 1) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        tok = random_token(fill, phase_hb[p], phase_lb[p]);
        send_token(tok);
        if (!tok.is_match && tok.literal_symbol != END_MARK) fill++;
      end
    end
    drain_results();

    $display("Ran %0d tokens (%0d matches) over %0d settings: %0d results, %0d bytes",
             tokens_seen, matches_seen, NUM_PHASES + 1, results_seen, bytes_seen);
    $display("Covered end of stream, high literals, unwritten history, %0d-cycle stall",
             LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[lzss_token_decoder_top.f]
sv/lzss_td_pkg.sv
sv/lzss_td_ram.sv
sv/lzss_td_cfg.sv
sv/lzss_td_engine.sv
sv/lzss_token_decoder_top.sv
sv/lzss_td_checker.sv
tb/lzss_td_checker.sv
tb/tb_lzss_token_decoder_top.sv
